### src/fvp_pkg.sv
// shared types, constants and codes for the four-voice pcm sample player
`default_nettype none
package fvp_pkg;

  // number of voices that play; register slots for the rest are still stored
  localparam int VOICE_COUNT = 4;
  // voice slots addressed by the two upper register offset bits
  localparam int NUM_SLOTS = 4;
  localparam logic [1:0] VOICE_LAST = 2'(VOICE_COUNT - 1);

  localparam int ADDR_W   = 21;
  localparam int SAMPLE_W = 18;
  localparam int PROD_W   = 17;
  localparam int CNT_W    = 9;
  localparam int REG_DEPTH = 32;

  localparam logic [ADDR_W-1:0] ROM_SIZE_RESET = 21'h100000;
  localparam logic [CNT_W-1:0]  RELOAD         = 9'h100;
  localparam logic [8:0]        MIDPOINT       = 9'h080;
  localparam logic [8:0]        VOL_BIAS       = 9'd10;

  // register functions within a voice's eight-byte slot
  localparam logic [2:0] FUNC_RATE   = 3'd4;
  localparam logic [2:0] FUNC_VOLUME = 3'd5;
  localparam logic [2:0] FUNC_KEY    = 3'd6;
  localparam logic [2:0] FUNC_START_LO = 3'd0;
  localparam logic [2:0] FUNC_START_HI = 3'd1;
  localparam int KEY_ON_BIT = 1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef struct packed {
    logic              playing;
    logic [ADDR_W-1:0] position;
    logic [CNT_W-1:0]  countdown;
    logic [7:0]        rate;
    logic [7:0]        volume;
  } voice_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_STORE,
    ST_DIV,
    ST_KEY_LO,
    ST_KEY_HI,
    ST_KEY_SET,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

### src/fvp_div.sv
// restoring divider for the volume curve v*256/(v+10), one quotient bit a cycle
`default_nettype none
module fvp_div
  import fvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] value,
  output logic [7:0] quotient,
  output logic       done
);

  logic       busy;
  logic [2:0] cnt;
  logic [8:0] divisor;
  logic [9:0] rem;
  logic [9:0] shifted;
  logic       fits;

  // low byte of the dividend is zero, so only zeros shift in
  assign shifted = {rem[8:0], 1'b0};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor  <= {1'b0, value} + VOL_BIAS;
      rem      <= {2'b00, value};
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? (shifted - {1'b0, divisor}) : shifted;
      quotient <= {quotient[6:0], fits};
    end
  end

endmodule
`default_nettype wire

### src/fvp_voice_unit.sv
// shared per-voice step unit: end test, contribution product, countdown and advance
`default_nettype none
module fvp_voice_unit
  import fvp_pkg::*;
(
  input  voice_t                    cur,
  input  logic [7:0]                rom_byte,
  input  logic [ADDR_W-1:0]         rom_size,
  output voice_t                    nxt,
  output logic signed [PROD_W-1:0]  product
);

  logic [7:0]              byte_eff;
  logic signed [8:0]       centered;
  logic signed [17:0]      full_prod;
  logic [CNT_W-1:0]        cnt_dec;

  assign byte_eff  = (cur.position >= rom_size) ? 8'd0 : rom_byte;
  assign centered  = $signed({1'b0, byte_eff} - MIDPOINT);
  assign full_prod = centered * $signed({1'b0, cur.volume});
  assign cnt_dec   = cur.countdown - 9'd1;

  always_comb begin
    nxt     = cur;
    product = '0;
    if (cur.playing) begin
      if (byte_eff == 8'd0) begin
        nxt.playing = 1'b0;
      end else begin
        product = full_prod[PROD_W-1:0];
        if (cnt_dec <= {1'b0, cur.rate}) begin
          nxt.position  = cur.position + 21'd1;
          nxt.countdown = RELOAD;
        end else begin
          nxt.countdown = cnt_dec;
        end
      end
    end
  end

endmodule
`default_nettype wire

### src/four_voice_pcm_sample_player.sv
// top level of the four-voice pcm sample player: sequencer, register file and voice state
`default_nettype none
// Four-voice 8-bit PCM player. Each input transaction is either a register
// write (tuser = 0) into the 32-byte register file or one chip step (tuser = 1)
// that carries the ROM byte each voice fetched. Every input transaction yields
// exactly one output transaction with the mixed sample (zero for a write),
// the play-status bits and the ROM address each voice fetches on the next
// step. One item is in work at a time. A step walks the voices through a
// single shared step unit, one voice a cycle, and its result is registered.
// A key-on reads the start word from the register file twice (one port),
// a volume write runs a bit-serial divider for the v*256/(v+10) curve. The
// output register lets a new transaction be accepted while the last result
// still waits. The user must write rom_size on the cfg port only while the
// block is idle; the block itself does not enforce this.
module four_voice_pcm_sample_player
  import fvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // slave side: tdata = reg_offset[4:0], reg_value[12:5], rom_byte_voice0[20:13],
  // rom_byte_voice1[28:21], rom_byte_voice2[36:29], rom_byte_voice3[44:37], zero pad
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [47:0]       s_axis_tdata,
  // tuser = mode (0 register write, 1 chip step)
  input  logic              s_axis_tuser,
  // master side: tdata = mixed_sample[17:0], play_status[21:18],
  // fetch_addr_voice0[42:22], fetch_addr_voice1[63:43],
  // fetch_addr_voice2[84:64], fetch_addr_voice3[105:85], zero pad
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [111:0]      m_axis_tdata,
  // rom_size configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data
);

  state_t state, state_next;

  // latched item
  logic       item_mode;
  logic [4:0] item_offset;
  logic [7:0] item_value;
  logic [7:0] item_bytes [NUM_SLOTS];

  logic [1:0] item_voice;
  logic [2:0] item_func;
  logic       voice_active;

  logic [ADDR_W-1:0] rom_size;
  voice_t            voices [NUM_SLOTS];

  // step sequencer and accumulator
  logic [1:0]                vidx;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SAMPLE_W-1:0] acc;
  logic signed [SAMPLE_W-1:0] sample_sum;

  // register file memory with per-entry valid bits (reset reads as zero)
  logic [7:0]           regmem [REG_DEPTH];
  logic [REG_DEPTH-1:0] reg_valid;
  logic [4:0]           mem_raddr;
  logic [7:0]           rd_data;
  logic                 rd_ok;
  logic [7:0]           rd_eff;
  logic [7:0]           start_lo;

  // shared units
  voice_t                   unit_nxt;
  logic signed [PROD_W-1:0] unit_prod;
  logic                     div_start;
  logic                     div_done;
  logic [7:0]               div_q;

  logic accept;
  logic out_free;
  logic out_load;
  logic [3:0]  status_bits;
  logic [ADDR_W-1:0] fetch_addr [NUM_SLOTS];

  assign accept       = s_axis_tvalid && s_axis_tready;
  assign out_free     = !m_axis_tvalid || m_axis_tready;
  assign item_voice   = item_offset[4:3];
  assign item_func    = item_offset[2:0];
  assign voice_active = 32'(item_voice) < VOICE_COUNT;
  assign cfg_ready    = 1'b1;
  assign rd_eff       = rd_ok ? rd_data : 8'd0;
  assign sample_sum   = acc + {prod[PROD_W-1], prod};

  // start word lives at functions 0 and 1 of the voice slot
  assign mem_raddr = (state == ST_KEY_LO) ? {item_voice, FUNC_START_LO}
                                          : {item_voice, FUNC_START_HI};

  fvp_voice_unit u_voice (
    .cur      (voices[vidx]),
    .rom_byte (item_bytes[vidx]),
    .rom_size (rom_size),
    .nxt      (unit_nxt),
    .product  (unit_prod)
  );

  fvp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .value    (item_value),
    .quotient (div_q),
    .done     (div_done)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control outputs
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser == MODE_STEP) ? ST_STEP : ST_STORE;
        end
      end
      ST_STEP: begin
        if (vidx == VOICE_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_STORE: begin
        if (voice_active && item_func == FUNC_VOLUME) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else if (voice_active && item_func == FUNC_KEY && item_value[KEY_ON_BIT]) begin
          state_next = ST_KEY_LO;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_KEY_LO:  state_next = ST_KEY_HI;
      ST_KEY_HI:  state_next = ST_KEY_SET;
      ST_KEY_SET: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state: voices, rom size, valid bits, sequencer, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size      <= ROM_SIZE_RESET;
      reg_valid     <= '0;
      vidx          <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        voices[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        rom_size <= cfg_data;
      end
      if (accept) begin
        vidx <= '0;
      end
      case (state)
        ST_STEP: begin
          voices[vidx] <= unit_nxt;
          vidx         <= vidx + 2'd1;
        end
        ST_STORE: begin
          reg_valid[item_offset] <= 1'b1;
          if (voice_active && item_func == FUNC_RATE) begin
            voices[item_voice].rate <= item_value;
          end
          if (voice_active && item_func == FUNC_KEY && !item_value[KEY_ON_BIT]) begin
            voices[item_voice].playing <= 1'b0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            voices[item_voice].volume <= div_q;
          end
        end
        ST_KEY_SET: begin
          voices[item_voice].playing   <= 1'b1;
          voices[item_voice].position  <= {1'b0, rd_eff, start_lo, 4'b0000};
          voices[item_voice].countdown <= RELOAD;
        end
        default: ;
      endcase
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload: latched item, product pipeline, start byte
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode   <= s_axis_tuser;
      item_offset <= s_axis_tdata[4:0];
      item_value  <= s_axis_tdata[12:5];
      for (int i = 0; i < NUM_SLOTS; i++) begin
        item_bytes[i] <= s_axis_tdata[13 + 8*i +: 8];
      end
      acc  <= '0;
      prod <= '0;
    end else if (state == ST_STEP) begin
      // product of one voice is registered before it is added to the accumulator
      prod <= unit_prod;
      acc  <= sample_sum;
    end
    if (state == ST_KEY_HI) begin
      start_lo <= rd_eff;
    end
  end

  // register file memory
  always_ff @(posedge clk) begin
    if (state == ST_STORE) begin
      regmem[item_offset] <= item_value;
    end
    rd_data <= regmem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= reg_valid[mem_raddr];
    end
  end

  // result fields, slots past the voice count report nothing
  always_comb begin
    status_bits = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      fetch_addr[i] = '0;
      if (i < VOICE_COUNT) begin
        status_bits[i] = voices[i].playing;
        fetch_addr[i]  = voices[i].position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, fetch_addr[3], fetch_addr[2], fetch_addr[1], fetch_addr[0],
                       status_bits,
                       (item_mode == MODE_STEP) ? sample_sum : '0};
    end
  end

`ifndef SYNTHESIS
  // one item in work at a time: after a transaction the input stays closed
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // a step visits every voice before its result is formed
  a_step_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP && vidx == VOICE_LAST |=> state == ST_FINISH)
    else $error("voice walk did not end in finish");

  // a result appears only out of the finish state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_FINISH)
    else $error("output valid raised outside finish");

  // a volume write leaves the divider stage only on its done pulse
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && !div_done |=> state == ST_DIV)
    else $error("divider stage left early");
`endif

endmodule
`default_nettype wire
